/* hw/rtl/sdbc_pkg.sv */
// sdbc_pkg: widths, constants and register codes of the spectrogram dB colormap core.
// No dependencies; imported by spectrogram_db_colormap_core.

package sdbc_pkg;

  // Magnitude word: unsigned fixed point, MAG_FRAC_BITS fractional bits
  localparam int MAG_BITS      = 32;
  localparam int MAG_FRAC_BITS = 16;
  localparam int MAG_W         = 32;
  localparam int MAG_USE       = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
  localparam int P_W           = $clog2(MAG_USE);

  // Normalized mantissa in Q1.30
  localparam int MANT_FRAC = 30;
  localparam int MANT_W    = MANT_FRAC + 1;
  localparam int EXT_W     = MAG_USE + MANT_FRAC;

  // log2 result: signed integer part plus LOG_FRAC fractional bits
  localparam int LOG_FRAC = 16;
  localparam int FRAC_W   = $clog2(MAG_FRAC_BITS + 1);
  localparam int LINT_W   = ((P_W > FRAC_W) ? P_W : FRAC_W) + 1;
  localparam int L_W      = LINT_W + LOG_FRAC;

  // dB scaling: 20*log10(2) in Q4.16, product shifted down to Q8.8
  localparam int K_W      = 20;
  localparam logic signed [K_W-1:0] DB_PER_LOG2 = K_W'(394566);
  localparam int PROD_W   = L_W + K_W;
  localparam int DB_SHIFT = 24;
  localparam int Q_W      = PROD_W - DB_SHIFT;
  localparam int DB_W     = 16;

  // Normalized level v in Q1.16, 0..65536
  localparam int V_FRAC = 16;
  localparam int V_W    = V_FRAC + 1;
  localparam logic [V_W-1:0] V_ONE = V_W'(1) << V_FRAC;

  // Pipelined restoring divider for the level
  localparam int DIV_W     = 16;
  localparam int DIV_ITERS = V_FRAC;
  localparam int DIV_STEPS = 2;
  localparam int DIV_STG   = (DIV_ITERS + DIV_STEPS - 1) / DIV_STEPS;

  // Pipelined square root of v * 2^16
  localparam int SQRT_ITERS = (V_W + V_FRAC + 1) / 2;
  localparam int SQ_W       = 2 * SQRT_ITERS;
  localparam int SQRT_STEPS = 2;
  localparam int SQRT_STG   = (SQRT_ITERS + SQRT_STEPS - 1) / SQRT_STEPS;

  localparam int COL_W = 8;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_FLOOR   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DB_CEILING = 1'd1;
  localparam logic [CFG_W-1:0]     DB_FLOOR_RST   = 16'h9C00;
  localparam logic [CFG_W-1:0]     DB_CEILING_RST = 16'h0000;

endpackage

/* hw/rtl/spectrogram_db_colormap_core.sv */
// spectrogram_db_colormap_core: magnitude to dB to normalized level to RGB pixel.
// Depends on sdbc_pkg (widths, constants, register codes).
//
//   port group | direction | word                         | flow control
//   in_        | input     | magnitude, unsigned Q16.16   | in_valid / in_stall
//   out_       | output    | red, green, blue (8 bit each) | out_valid / out_stall
//   cfg_       | input     | db_floor, db_ceiling (Q8.8)  | cfg_we, no wait
//
// One word enters per clock unless the pipeline holds; latency is set by the 16 squaring
// stages of the log2, the divider stages and the square root stages.
// Reset (synchronous, rst_n low) clears all valid bits and loads the default
// floor of -100 dB and ceiling of 0 dB.
// The whole pipeline holds while a result waits under out_stall; in_stall is
// raised only in that case.

module spectrogram_db_colormap_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sdbc_pkg::MAG_W-1:0]    in_magnitude,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sdbc_pkg::COL_W-1:0]    out_red,
  output logic [sdbc_pkg::COL_W-1:0]    out_green,
  output logic [sdbc_pkg::COL_W-1:0]    out_blue,
  input  logic                          cfg_we,
  input  logic [sdbc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdbc_pkg::CFG_W-1:0]    cfg_wdata
);
  import sdbc_pkg::*;

  // Stage positions in the valid chain
  localparam int NORM_IDX = 1;
  localparam int DBA_IDX  = NORM_IDX + LOG_FRAC + 1;
  localparam int DIV0_IDX = DBA_IDX + 1;
  localparam int SQ0_IDX  = DIV0_IDX + DIV_STG;
  localparam int OUT_IDX  = SQ0_IDX + SQRT_STG + 1;
  localparam int N_STG    = OUT_IDX + 1;

  function automatic logic [COL_W-1:0] scale255(input logic [V_W-1:0] a);
    logic [V_W+COL_W-1:0] t;
    t = {a, COL_W'(0)} - {COL_W'(0), a};
    return t[V_FRAC+COL_W-1:V_FRAC];
  endfunction

  logic               adv;
  logic [N_STG-1:0]   vld_r;
  logic signed [CFG_W-1:0] floor_r;
  logic signed [CFG_W-1:0] ceil_r;

  // Advance everything unless a finished word is held at the output
  assign adv       = !(vld_r[OUT_IDX] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[OUT_IDX];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r <= DB_FLOOR_RST;
      ceil_r  <= DB_CEILING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DB_FLOOR:   floor_r <= cfg_wdata;
        CFG_DB_CEILING: ceil_r  <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N_STG-2:0], in_valid};
    end
  end

  // Input register
  logic [MAG_USE-1:0] m_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      m_r <= in_magnitude[MAG_USE-1:0];
    end
  end

  // Normalize: find the leading one and shift the mantissa to Q1.30
  logic [P_W-1:0]    lead;
  logic [P_W-1:0]    lz;
  logic [EXT_W-1:0]  ext_sh;
  always_comb begin
    lead = '0;
    for (int i = 0; i < MAG_USE; i++) begin
      if (m_r[i]) lead = P_W'(i);
    end
    lz     = P_W'(MAG_USE - 1) - lead;
    ext_sh = {m_r, MANT_FRAC'(0)} << lz;
  end

  logic [MANT_W-1:0]   sq_n_r    [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] sq_frac_r [0:LOG_FRAC];
  logic [P_W-1:0]      sq_p_r    [0:LOG_FRAC];
  logic                sq_zero_r [0:LOG_FRAC];

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_n_r[0]    <= ext_sh[EXT_W-1 -: MANT_W];
      sq_frac_r[0] <= '0;
      sq_p_r[0]    <= lead;
      sq_zero_r[0] <= (m_r == '0);
    end
  end

  // Squaring stages: one fractional log2 bit per stage, msb first
  for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     t;
    assign sq = sq_n_r[k-1] * sq_n_r[k-1];
    assign t  = sq[2*MANT_W-1:MANT_FRAC];
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_n_r[k]    <= t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
        sq_frac_r[k] <= {sq_frac_r[k-1][LOG_FRAC-2:0], t[MANT_W]};
        sq_p_r[k]    <= sq_p_r[k-1];
        sq_zero_r[k] <= sq_zero_r[k-1];
      end
    end
  end

  // dB, first half: scale log2 by 20*log10(2)
  logic signed [L_W-1:0]    l_s;
  logic signed [PROD_W-1:0] prod_r;
  logic                     dba_zero_r;
  assign l_s = {LINT_W'(sq_p_r[LOG_FRAC]) - LINT_W'(MAG_FRAC_BITS), sq_frac_r[LOG_FRAC]};
  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r     <= l_s * DB_PER_LOG2;
      dba_zero_r <= sq_zero_r[LOG_FRAC];
    end
  end

  // dB, second half: floor shift, saturate, classify against floor and ceiling
  logic [Q_W-1:0]           q;
  logic signed [DB_W-1:0]   db;
  logic signed [DB_W:0]     num;
  logic signed [DB_W:0]     den;
  logic                     db_ge_ceil;
  logic                     db_le_floor;
  always_comb begin
    q = prod_r[PROD_W-1:DB_SHIFT];
    if ((&q[Q_W-1:DB_W-1]) || !(|q[Q_W-1:DB_W-1])) begin
      db = q[DB_W-1:0];
    end else if (q[Q_W-1]) begin
      db = {1'b1, (DB_W-1)'(0)};
    end else begin
      db = {1'b0, {(DB_W-1){1'b1}}};
    end
    num         = {db[DB_W-1], db} - {floor_r[CFG_W-1], floor_r};
    den         = {ceil_r[CFG_W-1], ceil_r} - {floor_r[CFG_W-1], floor_r};
    db_ge_ceil  = (db >= ceil_r);
    db_le_floor = (db <= floor_r);
  end

  logic [DIV_W-1:0] dv_rem_r [0:DIV_STG];
  logic [DIV_W-1:0] dv_den_r [0:DIV_STG];
  logic [DIV_W-1:0] dv_q_r   [0:DIV_STG];
  logic             dv_en_r  [0:DIV_STG];
  logic [V_W-1:0]   dv_fix_r [0:DIV_STG];

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= num[DIV_W-1:0];
      dv_den_r[0] <= den[DIV_W-1:0];
      dv_q_r[0]   <= '0;
      dv_en_r[0]  <= !dba_zero_r && (ceil_r > floor_r) && !db_le_floor && !db_ge_ceil;
      dv_fix_r[0] <= (!dba_zero_r && db_ge_ceil) ? V_ONE : '0;
    end
  end

  // Divider stages: DIV_STEPS quotient bits per stage, remainder kept below den
  for (genvar d = 1; d <= DIV_STG; d++) begin : g_div
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] quo;
    logic [DIV_W:0]   tw;
    always_comb begin
      rem = dv_rem_r[d-1];
      quo = dv_q_r[d-1];
      tw  = '0;
      for (int t = 0; t < DIV_STEPS; t++) begin
        if ((d - 1) * DIV_STEPS + t < DIV_ITERS) begin
          tw = {rem, 1'b0};
          if (tw >= {1'b0, dv_den_r[d-1]}) begin
            tw  = tw - {1'b0, dv_den_r[d-1]};
            quo = {quo[DIV_W-2:0], 1'b1};
          end else begin
            quo = {quo[DIV_W-2:0], 1'b0};
          end
          rem = tw[DIV_W-1:0];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[d] <= rem;
        dv_den_r[d] <= dv_den_r[d-1];
        dv_q_r[d]   <= quo;
        dv_en_r[d]  <= dv_en_r[d-1];
        dv_fix_r[d] <= dv_fix_r[d-1];
      end
    end
  end

  // Level v, then square root of v * 2^16 over SQRT_STG stages
  logic [V_W-1:0]  lvl;
  assign lvl = dv_en_r[DIV_STG] ? {1'b0, dv_q_r[DIV_STG]} : dv_fix_r[DIV_STG];

  logic [SQ_W-1:0] sr_x_r [1:SQRT_STG];
  logic [SQ_W-1:0] sr_r_r [1:SQRT_STG];
  logic [V_W-1:0]  sr_v_r [1:SQRT_STG];

  for (genvar s = 1; s <= SQRT_STG; s++) begin : g_sqrt
    logic [SQ_W-1:0] x_in;
    logic [SQ_W-1:0] r_in;
    logic [V_W-1:0]  v_in;
    logic [SQ_W-1:0] x;
    logic [SQ_W-1:0] r;
    logic [SQ_W-1:0] b;
    if (s == 1) begin : g_first
      assign x_in = SQ_W'({lvl, V_FRAC'(0)});
      assign r_in = '0;
      assign v_in = lvl;
    end else begin : g_next
      assign x_in = sr_x_r[s-1];
      assign r_in = sr_r_r[s-1];
      assign v_in = sr_v_r[s-1];
    end
    always_comb begin
      x = x_in;
      r = r_in;
      b = '0;
      for (int t = 0; t < SQRT_STEPS; t++) begin
        if ((s - 1) * SQRT_STEPS + t < SQRT_ITERS) begin
          b = SQ_W'(1) << (2 * (SQRT_ITERS - 1 - ((s - 1) * SQRT_STEPS + t)));
          if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
          end else begin
            r = r >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sr_x_r[s] <= x;
        sr_r_r[s] <= r;
        sr_v_r[s] <= v_in;
      end
    end
  end

  // Color mapping into the output register
  logic [COL_W-1:0] red_r;
  logic [COL_W-1:0] green_r;
  logic [COL_W-1:0] blue_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      red_r   <= scale255(sr_v_r[SQRT_STG]);
      green_r <= scale255(sr_r_r[SQRT_STG][V_W-1:0]);
      blue_r  <= scale255(V_ONE - sr_v_r[SQRT_STG]);
    end
  end

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

`ifndef SYNTHESIS
  // Normalized mantissa of a nonzero magnitude has its leading one at bit 30
  a_norm_lead: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NORM_IDX] && !sq_zero_r[0] |-> sq_n_r[0][MANT_W-1])
    else $error("mantissa not normalized");

  // Divider remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ0_IDX] && dv_en_r[DIV_STG] |-> dv_rem_r[DIV_STG] < dv_den_r[DIV_STG])
    else $error("divider remainder out of range");

  // Level and root never exceed one
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[OUT_IDX - 1] |-> sr_v_r[SQRT_STG] <= V_ONE &&
                           sr_r_r[SQRT_STG] <= SQ_W'(V_ONE))
    else $error("level or root above one");

  // Red and blue are complementary up to one step of truncation
  a_red_blue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_red} + {1'b0, out_blue} == 9'd255) ||
                  ({1'b0, out_red} + {1'b0, out_blue} == 9'd254))
    else $error("red and blue not complementary");
`endif

endmodule
